/* rtl/core/vrra_pkg.sv */
`default_nettype none

package vrra_pkg;

   // Fixed field widths
   localparam int LEN_W    = 21;
   localparam int STATUS_W = 2;

   // Default configuration
   localparam int              RING_DEPTH_DEF   = 16;
   localparam longint unsigned REGION_BYTES_DEF = 64'd1048576;
   localparam int              IDX_W_DEF        = $clog2(RING_DEPTH_DEF);

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_TOO_LONG   = 2'd1,
      STAT_WALK_BOUND = 2'd2
   } status_type;

   // Allocation sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_HEAD,
      ST_RD_TAIL,
      ST_WALK,
      ST_COMMIT
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/vrra_req_if.sv */
`default_nettype none

interface vrra_req_if;
   import vrra_pkg::*;

   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] record_length;

   modport source (output valid, output record_length, input ready);
   modport sink   (input valid, input record_length, output ready);
endinterface

`default_nettype wire

/* rtl/core/vrra_rsp_if.sv */
`default_nettype none

interface vrra_rsp_if #(
   parameter int IDX_W = vrra_pkg::IDX_W_DEF
);
   import vrra_pkg::*;

   logic                valid;
   logic                ready;
   logic [LEN_W-1:0]    write_offset;
   logic [IDX_W-1:0]    head_index;
   logic [IDX_W-1:0]    tail_index;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output write_offset, output head_index,
                   output tail_index, output status, input ready);
   modport sink   (input valid, input write_offset, input head_index,
                   input tail_index, input status, output ready);
endinterface

`default_nettype wire

/* rtl/core/vrra_ring_mem.sv */
`default_nettype none

module vrra_ring_mem #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4,
   parameter int OFF_W = 21
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic      [OFF_W-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [OFF_W-1:0] wr_data
);

   logic [OFF_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [OFF_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // Entry storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Written flags: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* rtl/core/vrra_ctrl.sv */
`default_nettype none

module vrra_ctrl #(
   parameter int              RING_DEPTH   = 16,
   parameter longint unsigned REGION_BYTES = 64'd1048576,
   parameter int              IDX_W        = 4,
   parameter int              OFF_W        = 21
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request side
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [vrra_pkg::LEN_W-1:0]   req_length,
   // result side
   input  wire logic                         rsp_free,
   output logic                              done,
   output logic      [vrra_pkg::LEN_W-1:0]   res_offset,
   output logic      [IDX_W-1:0]             res_head,
   output logic      [IDX_W-1:0]             res_tail,
   output vrra_pkg::status_type              res_status,
   // ring memory
   output logic      [IDX_W-1:0]             rd_addr,
   input  wire logic [OFF_W-1:0]             rd_data,
   output logic                              wr_en,
   output logic      [IDX_W-1:0]             wr_addr,
   output logic      [OFF_W-1:0]             wr_data
);
   import vrra_pkg::*;

   localparam int AW     = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;
   localparam int STEP_W = $clog2(RING_DEPTH + 1);
   localparam logic [AW-1:0]     REGION_AW = AW'(REGION_BYTES);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(RING_DEPTH - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RING_DEPTH - 1);

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   // True when moving from 'from' to 'to' crosses 'mark', wrapped or not
   function automatic logic passes(input logic [OFF_W-1:0] from,
                                   input logic [OFF_W-1:0] mark,
                                   input logic [OFF_W-1:0] to);
      passes = ((from < mark) && (mark < to)) ||
               ((mark < from) && (mark < to) && (to < from));
   endfunction

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [IDX_W-1:0]  cand_ff, cand_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [OFF_W-1:0]  head_off_ff, head_off_in;
   logic [OFF_W-1:0]  tail_off_ff, tail_off_in;
   logic [OFF_W-1:0]  insert_ff, insert_in;
   logic [OFF_W-1:0]  new_end_ff, new_end_in;
   logic              reject_ff, reject_in;
   status_type        status_ff, status_in;

   logic [AW-1:0]     len_aw;
   logic [AW-1:0]     head_off_aw;
   logic [AW-1:0]     sum_aw;
   logic [AW-1:0]     insert_aw;
   logic [IDX_W-1:0]  head_adv;
   logic [IDX_W-1:0]  tail_adv;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      steps_ff    <= steps_in;
      len_ff      <= len_in;
      head_off_ff <= head_off_in;
      tail_off_ff <= tail_off_in;
      insert_ff   <= insert_in;
      new_end_ff  <= new_end_in;
      reject_ff   <= reject_in;
      status_ff   <= status_in;
   end

   // Arithmetic helpers
   assign len_aw      = AW'(len_ff);
   assign head_off_aw = AW'(rd_data);
   assign sum_aw      = head_off_aw + len_aw;
   assign insert_aw   = AW'(insert_ff);
   assign head_adv    = ring_next(head_ff);
   assign tail_adv    = (tail_ff == head_adv) ? ring_next(tail_ff) : tail_ff;

   // Next state and outputs
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cand_in     = cand_ff;
      steps_in    = steps_ff;
      len_in      = len_ff;
      head_off_in = head_off_ff;
      tail_off_in = tail_off_ff;
      insert_in   = insert_ff;
      new_end_in  = new_end_ff;
      reject_in   = reject_ff;
      status_in   = status_ff;
      rd_addr     = head_ff;
      wr_en       = 1'b0;
      done        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            rd_addr = head_ff;
            if (req_valid) begin
               len_in = req_length;
               if (AW'(req_length) > REGION_AW) begin
                  reject_in = 1'b1;
                  status_in = STAT_TOO_LONG;
                  state_in  = ST_COMMIT;
               end else begin
                  reject_in = 1'b0;
                  status_in = STAT_OK;
                  state_in  = ST_RD_HEAD;
               end
            end
         end
         ST_RD_HEAD: begin
            // head offset arrives; place record, wrap to zero past region end
            rd_addr     = tail_ff;
            head_off_in = rd_data;
            if (sum_aw > REGION_AW) begin
               insert_in  = '0;
               new_end_in = len_aw[OFF_W-1:0];
            end else begin
               insert_in  = rd_data;
               new_end_in = sum_aw[OFF_W-1:0];
            end
            state_in = ST_RD_TAIL;
         end
         ST_RD_TAIL: begin
            rd_addr = ring_next(tail_ff);
            if (passes(head_off_ff, rd_data, new_end_ff)) begin
               tail_off_in = rd_data;
               cand_in     = ring_next(tail_ff);
               steps_in    = STEP_W'(1);
               state_in    = ST_WALK;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_WALK: begin
            // one candidate entry per cycle
            rd_addr = ring_next(cand_ff);
            if (passes(tail_off_ff, new_end_ff, rd_data)) begin
               tail_in  = cand_ff;
               state_in = ST_COMMIT;
            end else if (steps_ff == LAST_STEP) begin
               tail_in   = head_ff;
               status_in = STAT_WALK_BOUND;
               state_in  = ST_COMMIT;
            end else begin
               tail_off_in = rd_data;
               cand_in     = ring_next(cand_ff);
               steps_in    = steps_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               if (!reject_ff) begin
                  wr_en   = 1'b1;
                  head_in = head_adv;
                  tail_in = tail_adv;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign wr_addr    = head_adv;
   assign wr_data    = new_end_ff;
   assign res_offset = reject_ff ? '0 : insert_aw[LEN_W-1:0];
   assign res_head   = reject_ff ? head_ff : head_adv;
   assign res_tail   = reject_ff ? tail_ff : tail_adv;
   assign res_status = status_ff;

   // Checks
   walk_in_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (steps_ff < STEP_W'(RING_DEPTH)))
      else $error("tail walk ran past ring depth");

   done_needs_slot: assert property (@(posedge clock) disable iff (reset)
      done |-> (rsp_free && (state_ff == ST_COMMIT)))
      else $error("result issued without a free output slot");

   reject_no_write: assert property (@(posedge clock) disable iff (reset)
      (reject_ff && (state_ff == ST_COMMIT)) |-> !wr_en)
      else $error("rejected request modified the ring");

   tail_clear_of_head: assert property (@(posedge clock) disable iff (reset)
      (done && !reject_ff) |=> (tail_ff != head_ff))
      else $error("tail collides with head after allocation");

endmodule

`default_nettype wire

/* rtl/core/variable_record_ring_allocator_unit.sv */
// Variable-length record ring allocator.
// req_chan carries one request: a record byte length. rsp_chan returns one
// result per request: the write offset in the region, the new head and tail
// ring indices, and a status (ok, length too long, tail walk bound hit).
// A request is taken only while the allocator is idle; ready drops until
// its result has been handed to the output register.
// Steps: an accepted length reads the head offset, then the tail offset,
// then, if the new end passes the tail, walks the tail over up to
// RING_DEPTH-1 entries, and commits; a rejected length goes to commit.
// The ring memory's single read port paces the walk (one end offset per cycle).
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver stalls longer, the following allocation
// holds in its commit step until the register frees, without losing data.
// Reset clears head, tail and per-entry written flags together: every
// ring entry reads as zero right away, no clearing pass is needed.
`default_nettype none

module variable_record_ring_allocator_unit #(
   parameter int              RING_DEPTH   = vrra_pkg::RING_DEPTH_DEF,
   parameter longint unsigned REGION_BYTES = vrra_pkg::REGION_BYTES_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   vrra_req_if.sink    req_chan,
   vrra_rsp_if.source  rsp_chan
);
   import vrra_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int OFF_W = $clog2(REGION_BYTES + 1);

   logic             done;
   logic             rsp_free;
   logic [LEN_W-1:0] res_offset;
   logic [IDX_W-1:0] res_head;
   logic [IDX_W-1:0] res_tail;
   status_type       res_status;
   logic [IDX_W-1:0] rd_addr;
   logic [OFF_W-1:0] rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [OFF_W-1:0] wr_data;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] rsp_offset_ff;
   logic [IDX_W-1:0] rsp_head_ff;
   logic [IDX_W-1:0] rsp_tail_ff;
   status_type       rsp_status_ff;

   vrra_ctrl #(
      .RING_DEPTH   (RING_DEPTH),
      .REGION_BYTES (REGION_BYTES),
      .IDX_W        (IDX_W),
      .OFF_W        (OFF_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_length (req_chan.record_length),
      .rsp_free   (rsp_free),
      .done       (done),
      .res_offset (res_offset),
      .res_head   (res_head),
      .res_tail   (res_tail),
      .res_status (res_status),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   vrra_ring_mem #(
      .DEPTH (RING_DEPTH),
      .IDX_W (IDX_W),
      .OFF_W (OFF_W)
   ) u_ring_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Output register
   assign rsp_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = done ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_offset_ff <= res_offset;
         rsp_head_ff   <= res_head;
         rsp_tail_ff   <= res_tail;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.write_offset = rsp_offset_ff;
   assign rsp_chan.head_index   = rsp_head_ff;
   assign rsp_chan.tail_index   = rsp_tail_ff;
   assign rsp_chan.status       = STATUS_W'(rsp_status_ff);

endmodule

`default_nettype wire

/* bench/variable_record_ring_allocator_unit_tb.sv */
`timescale 1ns / 1ps

module variable_record_ring_allocator_unit_tb;
   import vrra_pkg::*;

   localparam int              DEPTH      = RING_DEPTH_DEF;
   localparam longint unsigned REGION     = REGION_BYTES_DEF;
   localparam int              IDX_W      = IDX_W_DEF;
   localparam int              MAX_CYCLES = 400000;
   localparam int              DRAIN_WAIT = 40;
   localparam int              RAND_ITEMS = 330;

   typedef struct {
      logic [LEN_W-1:0] write_offset;
      logic [IDX_W-1:0] head_index;
      logic [IDX_W-1:0] tail_index;
      status_type       status;
   } alloc_result_type;

   // Mirror of the allocator ring plus the queue of pending allocations
   class alloc_scoreboard;
      longint unsigned  end_ring[DEPTH];
      int unsigned      head_ptr;
      int unsigned      tail_ptr;
      alloc_result_type pending_q[$];
      int               errors;

      function new();
         foreach (end_ring[i]) end_ring[i] = 0;
         head_ptr = 0;
         tail_ptr = 0;
         errors   = 0;
      endfunction

      // Does an end at 'to' overtake 'mark' starting from 'from' (wrap included)
      function bit overtakes(longint unsigned from, longint unsigned mark,
                             longint unsigned to);
         if (from < mark && mark < to) return 1;
         if (mark < from && mark < to && to < from) return 1;
         return 0;
      endfunction

      function int unsigned ring_next(int unsigned idx);
         return (idx + 1) % DEPTH;
      endfunction

      // Work out the allocation and advance the mirrored ring
      function alloc_result_type allocate(logic [LEN_W-1:0] len);
         longint unsigned  head_off, tail_off, place, new_end, cand_off;
         int unsigned      hd, tl, cand, steps, new_hd, new_tl;
         bit               cleared;
         alloc_result_type r;
         hd       = head_ptr;
         tl       = tail_ptr;
         r.status = STAT_OK;
         if (longint'(len) > REGION) begin
            r.write_offset = '0;
            r.head_index   = hd[IDX_W-1:0];
            r.tail_index   = tl[IDX_W-1:0];
            r.status       = STAT_TOO_LONG;
            return r;
         end
         head_off = end_ring[hd];
         tail_off = end_ring[tl];
         place    = (head_off + len > REGION) ? 0 : head_off;
         new_end  = place + len;
         // walk the tail until the oldest kept record is clear
         if (overtakes(head_off, tail_off, new_end)) begin
            cand    = ring_next(tl);
            steps   = 1;
            cleared = 0;
            while (steps < DEPTH && !cleared) begin
               cand_off = end_ring[cand];
               if (overtakes(tail_off, new_end, cand_off)) begin
                  cleared = 1;
               end else begin
                  tail_off = cand_off;
                  cand     = ring_next(cand);
                  steps++;
               end
            end
            if (cleared) begin
               tl = cand;
            end else begin
               tl       = hd;
               r.status = STAT_WALK_BOUND;
            end
         end
         new_hd           = ring_next(hd);
         new_tl           = (tl == new_hd) ? ring_next(tl) : tl;
         end_ring[new_hd] = new_end;
         head_ptr         = new_hd;
         tail_ptr         = new_tl;
         r.write_offset   = place[LEN_W-1:0];
         r.head_index     = new_hd[IDX_W-1:0];
         r.tail_index     = new_tl[IDX_W-1:0];
         return r;
      endfunction

      function void note_request(logic [LEN_W-1:0] len);
         pending_q.push_back(allocate(len));
      endfunction

      function void check_result(alloc_result_type got);
         alloc_result_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result off=%0d head=%0d tail=%0d st=%0d", $time,
                     got.write_offset, got.head_index, got.tail_index, got.status);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         if (got.write_offset !== want.write_offset || got.head_index !== want.head_index
             || got.tail_index !== want.tail_index || got.status !== want.status) begin
            $display("%0t: mismatch exp off=%0d head=%0d tail=%0d st=%0d", $time,
                     want.write_offset, want.head_index, want.tail_index, want.status);
            $display("%0t:          got off=%0d head=%0d tail=%0d st=%0d", $time,
                     got.write_offset, got.head_index, got.tail_index, got.status);
            errors++;
         end
      endfunction

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   tx_idle_pct;
   int   rx_idle_pct;

   alloc_scoreboard sb;

   vrra_req_if                     req_bus ();
   vrra_rsp_if #(.IDX_W(IDX_W))    rsp_bus ();

   variable_record_ring_allocator_unit #(
      .RING_DEPTH   (DEPTH),
      .REGION_BYTES (REGION)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Result check at the rising edge
   always @(posedge clock) begin
      alloc_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.write_offset = rsp_bus.write_offset;
         got.head_index   = rsp_bus.head_index;
         got.tail_index   = rsp_bus.tail_index;
         got.status       = status_type'(rsp_bus.status);
         sb.check_result(got);
      end
   end

   // Run limit
   initial begin
      repeat (MAX_CYCLES) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Drive one allocation request, with random idle cycles ahead of it
   task automatic send_request(input logic [LEN_W-1:0] len);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.record_length <= len;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(len);
   endtask

   // Random length: mostly in range, biased so the region wraps often
   function automatic logic [LEN_W-1:0] pick_length();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         return LEN_W'($urandom_range(32'(REGION + 1), 32'((1 << LEN_W) - 1)));
      end
      if (sel < 13) return '0;
      if (sel < 16) return LEN_W'(REGION);
      if (sel < 40) return LEN_W'($urandom_range(0, 4095));
      if (sel < 75) return LEN_W'($urandom_range(0, 131071));
      return LEN_W'($urandom_range(0, 32'(REGION)));
   endfunction

   task automatic run_random(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (RAND_ITEMS) send_request(pick_length());
   endtask

   // Main sequence
   initial begin
      logic [LEN_W-1:0] directed_len[$];
      sb                    = new();
      tx_idle_pct           = 0;
      rx_idle_pct           = 0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.record_length = '0;
      rsp_bus.ready         = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero length, tiny, full region, just over, all ones, then wrap and walk
      directed_len = '{21'd0, 21'd1, 21'd1048576, 21'd1048577, 21'h1FFFFF,
                       21'd1048575, 21'd600000, 21'd600000, 21'd1048576,
                       21'd300000, 21'd300000, 21'd300000, 21'd300000,
                       21'd0, 21'd4095, 21'd524288, 21'd524288, 21'd524288,
                       21'd1048576, 21'd1};
      tx_idle_pct = 21;
      rx_idle_pct = 81;
      foreach (directed_len[i]) send_request(directed_len[i]);

      run_random(21, 81);
      run_random(81, 21);
      run_random(0, 0);
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // drain outstanding results, then watch for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/vrra_pkg.sv
rtl/core/vrra_req_if.sv
rtl/core/vrra_rsp_if.sv
rtl/core/vrra_ring_mem.sv
rtl/core/vrra_ctrl.sv
rtl/core/variable_record_ring_allocator_unit.sv
bench/variable_record_ring_allocator_unit_tb.sv
